// ----- src/apr_pkg.sv -----
// Shared constants, types and tables for the axis point rotator.
`timescale 1ns / 1ps
`default_nettype none
package apr_pkg;

	// Pipeline sizing
	localparam int CORDIC_STAGES = 16;
	localparam int COORD_BITS    = 32;
	localparam int TURN_BITS     = 16;

	// CORDIC formats: x, y in Q2.30, angle in units of 2^-32 turn
	localparam int TRIG_W    = 32;
	localparam int ANG_W     = 32;
	localparam int TRIG_FRAC = 30;

	// Rotation datapath widths
	localparam int PROD_W = COORD_BITS + TRIG_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int RND_W  = SUM_W - TRIG_FRAC;

	// Start of transaction to result strobe
	localparam int LATENCY = CORDIC_STAGES + 5;

	// Reciprocal of the unbounded CORDIC gain in Q2.30
	localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 32'sd652032874;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic signed [ANG_W-1:0] ATAN_TURN [32] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
		32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
		32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
		32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
		32'sd652,       32'sd326,       32'sd163,       32'sd81,
		32'sd41,        32'sd20,        32'sd10,        32'sd5,
		32'sd3,         32'sd1,         32'sd1,         32'sd0
	};

	typedef enum logic [1:0] {
		AXIS_X    = 2'd0,
		AXIS_Y    = 2'd1,
		AXIS_Z    = 2'd2,
		AXIS_NONE = 2'd3
	} axis_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} trig_t;

	typedef struct packed {
		axis_t                        axis;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} point_t;

endpackage
`default_nettype wire

// ----- src/apr_cordic.sv -----
// Pipelined rotation-mode CORDIC giving cosine and sine of a binary angle.
`timescale 1ns / 1ps
`default_nettype none
module apr_cordic import apr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic [TURN_BITS-1:0] turn,
	output logic                 out_vld,
	output trig_t                trig
);

	localparam logic [TURN_BITS-1:0] EIGHTH_TURN = TURN_BITS'(1) << (TURN_BITS - 3);

	logic [TURN_BITS-1:0] turn_adj;
	logic [1:0]           quad;
	logic [TURN_BITS-1:0] resid;

	logic [CORDIC_STAGES:0]   vld_s;
	logic signed [TRIG_W-1:0] cx_s [CORDIC_STAGES+1];
	logic signed [TRIG_W-1:0] cy_s [CORDIC_STAGES+1];
	logic signed [ANG_W-1:0]  cz_s [CORDIC_STAGES+1];
	logic [1:0]               cq_s [CORDIC_STAGES+1];

	logic  out_vld_q;
	trig_t trig_q;
	trig_t trig_fix;

	// Nearest quadrant and the residual angle around it
	assign turn_adj = turn + EIGHTH_TURN;
	assign quad     = turn_adj[TURN_BITS-1 -: 2];
	assign resid    = turn - {quad, {(TURN_BITS-2){1'b0}}};

	// Entry stage: seed vector, residual angle in 2^-32 turn
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		cx_s[0] <= CORDIC_X0;
		cy_s[0] <= '0;
		cz_s[0] <= {resid, {(ANG_W-TURN_BITS){1'b0}}};
		cq_s[0] <= quad;
	end

	// One micro-rotation per stage
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		logic signed [TRIG_W-1:0] dx;
		logic signed [TRIG_W-1:0] dy;

		assign dx = cy_s[i] >>> i;
		assign dy = cx_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (!cz_s[i][ANG_W-1]) begin
				cx_s[i+1] <= cx_s[i] - dx;
				cy_s[i+1] <= cy_s[i] + dy;
				cz_s[i+1] <= cz_s[i] - ATAN_TURN[i];
			end else begin
				cx_s[i+1] <= cx_s[i] + dx;
				cy_s[i+1] <= cy_s[i] - dy;
				cz_s[i+1] <= cz_s[i] + ATAN_TURN[i];
			end
			cq_s[i+1] <= cq_s[i];
		end
	end

	// Turn the result back by the quadrant
	always_comb begin
		case (cq_s[CORDIC_STAGES])
			2'd0: begin
				trig_fix.cos_v = cx_s[CORDIC_STAGES];
				trig_fix.sin_v = cy_s[CORDIC_STAGES];
			end
			2'd1: begin
				trig_fix.cos_v = -cy_s[CORDIC_STAGES];
				trig_fix.sin_v = cx_s[CORDIC_STAGES];
			end
			2'd2: begin
				trig_fix.cos_v = -cx_s[CORDIC_STAGES];
				trig_fix.sin_v = -cy_s[CORDIC_STAGES];
			end
			default: begin
				trig_fix.cos_v = cy_s[CORDIC_STAGES];
				trig_fix.sin_v = -cx_s[CORDIC_STAGES];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= vld_s[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		trig_q <= trig_fix;
	end

	assign out_vld = out_vld_q;
	assign trig    = trig_q;

endmodule
`default_nettype wire

// ----- src/apr_rotate.sv -----
// Plane rotation of a point: multiply, sum, round, saturate and route.
`timescale 1ns / 1ps
`default_nettype none
module apr_rotate import apr_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  trig_t                        trig,
	input  point_t                       pt,
	output logic                         done,
	output logic signed [COORD_BITS-1:0] rot_x,
	output logic signed [COORD_BITS-1:0] rot_y,
	output logic signed [COORD_BITS-1:0] rot_z,
	output logic                         clipped
);

	localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) <<< (TRIG_FRAC - 1);
	localparam logic signed [RND_W-1:0] TOP      = RND_W'({1'b0, {(COORD_BITS-1){1'b1}}});
	localparam logic signed [RND_W-1:0] BOT      = ~TOP;

	// Clamp to the coordinate range, flag in the top bit
	function automatic logic [COORD_BITS:0] sat(input logic signed [RND_W-1:0] v);
		logic [COORD_BITS:0] r;
		if (v > TOP) begin
			r = {1'b1, TOP[COORD_BITS-1:0]};
		end else if (v < BOT) begin
			r = {1'b1, BOT[COORD_BITS-1:0]};
		end else begin
			r = {1'b0, v[COORD_BITS-1:0]};
		end
		return r;
	endfunction

	logic signed [COORD_BITS-1:0] u_sel;
	logic signed [COORD_BITS-1:0] v_sel;

	logic                     vld_s1;
	point_t                   pt_s1;
	logic signed [PROD_W-1:0] uc_s1;
	logic signed [PROD_W-1:0] vs_s1;
	logic signed [PROD_W-1:0] us_s1;
	logic signed [PROD_W-1:0] vc_s1;

	logic                    vld_s2;
	point_t                  pt_s2;
	logic signed [SUM_W-1:0] pu_s2;
	logic signed [SUM_W-1:0] pv_s2;

	logic signed [SUM_W-1:0] pu_adj;
	logic signed [SUM_W-1:0] pv_adj;
	logic signed [RND_W-1:0] pu_rnd;
	logic signed [RND_W-1:0] pv_rnd;
	logic [COORD_BITS:0]     pu_sat;
	logic [COORD_BITS:0]     pv_sat;

	logic signed [COORD_BITS-1:0] nx;
	logic signed [COORD_BITS-1:0] ny;
	logic signed [COORD_BITS-1:0] nz;
	logic                         nclip;

	logic                         done_q;
	logic signed [COORD_BITS-1:0] rot_x_q;
	logic signed [COORD_BITS-1:0] rot_y_q;
	logic signed [COORD_BITS-1:0] rot_z_q;
	logic                         clipped_q;

	// Pick the two in-plane coordinates (u, v), rotated u towards v
	always_comb begin
		case (pt.axis)
			AXIS_X: begin
				u_sel = pt.y;
				v_sel = pt.z;
			end
			AXIS_Y: begin
				u_sel = pt.z;
				v_sel = pt.x;
			end
			default: begin
				u_sel = pt.x;
				v_sel = pt.y;
			end
		endcase
	end

	// Stage 1: four products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		pt_s1 <= pt;
		uc_s1 <= PROD_W'(u_sel) * PROD_W'(trig.cos_v);
		vs_s1 <= PROD_W'(v_sel) * PROD_W'(trig.sin_v);
		us_s1 <= PROD_W'(u_sel) * PROD_W'(trig.sin_v);
		vc_s1 <= PROD_W'(v_sel) * PROD_W'(trig.cos_v);
	end

	// Stage 2: exact dot products
	always_ff @(posedge clk) begin
		pt_s2 <= pt_s1;
		pu_s2 <= SUM_W'(uc_s1) - SUM_W'(vs_s1);
		pv_s2 <= SUM_W'(us_s1) + SUM_W'(vc_s1);
	end

	// Stage 3: round half up, saturate, put back on the right axes
	assign pu_adj = pu_s2 + HALF_LSB;
	assign pv_adj = pv_s2 + HALF_LSB;
	assign pu_rnd = RND_W'(pu_adj >>> TRIG_FRAC);
	assign pv_rnd = RND_W'(pv_adj >>> TRIG_FRAC);
	assign pu_sat = sat(pu_rnd);
	assign pv_sat = sat(pv_rnd);

	always_comb begin
		nx    = pt_s2.x;
		ny    = pt_s2.y;
		nz    = pt_s2.z;
		nclip = pu_sat[COORD_BITS] | pv_sat[COORD_BITS];
		case (pt_s2.axis)
			AXIS_X: begin
				ny = pu_sat[COORD_BITS-1:0];
				nz = pv_sat[COORD_BITS-1:0];
			end
			AXIS_Y: begin
				nz = pu_sat[COORD_BITS-1:0];
				nx = pv_sat[COORD_BITS-1:0];
			end
			AXIS_Z: begin
				nx = pu_sat[COORD_BITS-1:0];
				ny = pv_sat[COORD_BITS-1:0];
			end
			default: begin
				nclip = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rot_x_q   <= nx;
		rot_y_q   <= ny;
		rot_z_q   <= nz;
		clipped_q <= nclip;
	end

	assign done    = done_q;
	assign rot_x   = rot_x_q;
	assign rot_y   = rot_y_q;
	assign rot_z   = rot_z_q;
	assign clipped = clipped_q;

endmodule
`default_nettype wire

// ----- src/axis_point_rotator_core.sv -----
// Top level of the axis point rotator: CORDIC, point delay line and rotation stages.
// Throughput: one transaction per cycle; busy is always low, the pipeline never stalls.
// Between an accepted start and done lie an entry register, one CORDIC micro-rotation
// per stage, a quadrant register and three rotation stages.
// done is a one-cycle strobe; the receiver cannot hold results off.
// Reset clears all valid bits at once; no clearing pass, payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
module axis_point_rotator_core import apr_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   axis,
	input  logic [TURN_BITS-1:0]         turn,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	input  logic signed [COORD_BITS-1:0] coord_z,
	output logic                         done,
	output logic signed [COORD_BITS-1:0] rot_x,
	output logic signed [COORD_BITS-1:0] rot_y,
	output logic signed [COORD_BITS-1:0] rot_z,
	output logic                         clipped
);

	localparam int PT_DELAY = CORDIC_STAGES + 2;
	localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	logic   accept;
	logic   trig_vld;
	trig_t  trig;
	point_t pt_in;
	point_t pt_s [PT_DELAY];

	// Always ready: a new transaction may enter each cycle
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	assign pt_in.axis = axis_t'(axis);
	assign pt_in.x    = coord_x;
	assign pt_in.y    = coord_y;
	assign pt_in.z    = coord_z;

	apr_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (accept),
		.turn    (turn),
		.out_vld (trig_vld),
		.trig    (trig)
	);

	// Hold the point alongside the CORDIC
	always_ff @(posedge clk) begin
		pt_s[0] <= pt_in;
		for (int i = 1; i < PT_DELAY; i++) begin
			pt_s[i] <= pt_s[i-1];
		end
	end

	apr_rotate u_rotate (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (trig_vld),
		.trig    (trig),
		.pt      (pt_s[PT_DELAY-1]),
		.done    (done),
		.rot_x   (rot_x),
		.rot_y   (rot_y),
		.rot_z   (rot_z),
		.clipped (clipped)
	);

	// Every accepted transaction produces a result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("result strobe missing after accepted transaction");

	// No result without a transaction accepted the latency earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result strobe without a matching transaction");

	// Pass-through axis code leaves the point untouched and unclipped
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(axis, LATENCY) == AXIS_NONE) |->
			(!clipped && rot_x == $past(coord_x, LATENCY)
			 && rot_y == $past(coord_y, LATENCY) && rot_z == $past(coord_z, LATENCY)))
		else $error("pass-through point altered");

	// A clipped result has at least one coordinate at a range bound
	a_clip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clipped) |->
			(rot_x == COORD_MAX || rot_x == COORD_MIN || rot_y == COORD_MAX
			 || rot_y == COORD_MIN || rot_z == COORD_MAX || rot_z == COORD_MIN))
		else $error("clipped set with no saturated coordinate");

endmodule
`default_nettype wire
